### design/pagc_pkg.sv
// ----------------------------------------------------------------------------
// pagc_pkg
// shared types, constants and register codes of the peak envelope agc
// ----------------------------------------------------------------------------
package pagc_pkg;

	localparam int GAIN_SHIFT   = 8;
	localparam int FRAC_BITS    = 15;
	localparam int SAMPLE_WIDTH = 32;

	localparam int LEVEL_W = 15;
	localparam int GAIN_W  = 23;
	localparam int OUT_W   = 47;
	localparam int ENV_W   = 48;
	localparam int MAG_W   = SAMPLE_WIDTH - 1;
	localparam int NUM_W   = LEVEL_W + GAIN_SHIFT + FRAC_BITS;
	localparam int IDX_W   = 3;
	localparam int DATA_W  = 23;

	localparam logic [GAIN_W-1:0] GAIN_LIMIT = {GAIN_W{1'b1}};
	localparam logic [GAIN_W-1:0] GAIN_UNITY = GAIN_W'(1) << GAIN_SHIFT;

	localparam logic [LEVEL_W-1:0] TARGET_RST  = LEVEL_W'(5000);
	localparam logic [LEVEL_W-1:0] FLOOR_RST   = LEVEL_W'(16);
	localparam logic [GAIN_W-1:0]  GMIN_RST    = GAIN_W'(26);
	localparam logic [LEVEL_W-1:0] ATTACK_RST  = LEVEL_W'(512);
	localparam logic [LEVEL_W-1:0] RELEASE_RST = LEVEL_W'(1);

	typedef enum logic [IDX_W-1:0] {
		REG_ENABLE  = 3'd0,
		REG_TARGET  = 3'd1,
		REG_FLOOR   = 3'd2,
		REG_GMIN    = 3'd3,
		REG_ATTACK  = 3'd4,
		REG_RELEASE = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic               enable;
		logic [LEVEL_W-1:0] target;
		logic [LEVEL_W-1:0] floor_lvl;
		logic [GAIN_W-1:0]  gmin;
		logic [LEVEL_W-1:0] attack;
		logic [LEVEL_W-1:0] release_c;
		logic               restart;
	} cfg_t;

	typedef struct packed {
		logic signed [SAMPLE_WIDTH-1:0] sample;
		logic [MAG_W-1:0]               mag;
	} item_t;

	typedef struct packed {
		logic idle;
		logic div_busy;
	} back_st_t;

endpackage

### design/pagc_front.sv
// ----------------------------------------------------------------------------
// pagc_front
// accepts samples, forms the saturated magnitude, feeds the queue
// ----------------------------------------------------------------------------
module pagc_front (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic signed [pagc_pkg::SAMPLE_WIDTH-1:0] sample,
	output logic                                  push,
	output pagc_pkg::item_t                       push_item,
	input  logic                                  q_full
);
	import pagc_pkg::*;

	logic  valid_s1;
	item_t item_s1;
	logic  [MAG_W-1:0] mag;

	always_comb begin
		if (!sample[SAMPLE_WIDTH-1])
			mag = sample[MAG_W-1:0];
		else if (sample[MAG_W-1:0] == '0)
			mag = {MAG_W{1'b1}};
		else
			mag = MAG_W'(-sample);
	end

	assign push      = valid_s1 && !q_full;
	assign push_item = item_s1;
	assign in_stall  = valid_s1 && q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1.sample <= sample;
			item_s1.mag    <= mag;
		end
	end

endmodule

### design/pagc_queue.sv
// ----------------------------------------------------------------------------
// pagc_queue
// two-entry queue between front and back
// ----------------------------------------------------------------------------
module pagc_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  pagc_pkg::item_t push_item,
	output logic            full,
	input  logic            pop,
	output logic            not_empty,
	output pagc_pkg::item_t pop_item
);
	import pagc_pkg::*;

	item_t      mem_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;

	assign full      = cnt_q == 2'd2;
	assign not_empty = cnt_q != 2'd0;
	assign pop_item  = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= !wr_q;
			if (pop) rd_q <= !rd_q;
			if (push && !pop) cnt_q <= cnt_q + 2'd1;
			else if (pop && !push) cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_item;
	end

endmodule

### design/pagc_div.sv
// ----------------------------------------------------------------------------
// pagc_div
// radix-2 restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module pagc_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [pagc_pkg::NUM_W-1:0]  num,
	input  logic [pagc_pkg::ENV_W-1:0]  den,
	output logic                        busy,
	output logic                        done,
	output logic [pagc_pkg::NUM_W-1:0]  quot
);
	import pagc_pkg::*;

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [NUM_W-1:0] n_q;
	logic [ENV_W-1:0] d_q;
	logic [ENV_W:0]   rem_q;
	logic [ENV_W:0]   shifted;
	logic [ENV_W:0]   diff;

	assign shifted = {rem_q[ENV_W-1:0], n_q[NUM_W-1]};
	assign diff    = shifted - {1'b0, d_q};
	assign busy    = busy_q;
	assign done    = done_q;
	assign quot    = n_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q   <= num;
			d_q   <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			if (!diff[ENV_W]) begin
				rem_q <= diff;
				n_q   <= {n_q[NUM_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted;
				n_q   <= {n_q[NUM_W-2:0], 1'b0};
			end
		end
	end

endmodule

### design/pagc_back.sv
// ----------------------------------------------------------------------------
// pagc_back
// envelope update, gain division and clamp, output scaling
// ----------------------------------------------------------------------------
module pagc_back (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  pagc_pkg::cfg_t                         cfg,
	input  logic                                   q_not_empty,
	input  pagc_pkg::item_t                        q_item,
	output logic                                   pop,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic signed [pagc_pkg::OUT_W-1:0]      scaled_sample,
	output logic [pagc_pkg::GAIN_W-1:0]            current_gain,
	output pagc_pkg::back_st_t                     st
);
	import pagc_pkg::*;

	typedef enum logic [9:0] {
		S_IDLE = 10'b0000000001,
		S_CALC = 10'b0000000010,
		S_STEP = 10'b0000000100,
		S_UPD  = 10'b0000001000,
		S_DGS  = 10'b0000010000,
		S_DGW  = 10'b0000100000,
		S_DMS  = 10'b0001000000,
		S_DMW  = 10'b0010000000,
		S_CLMP = 10'b0100000000,
		S_MULT = 10'b1000000000
	} state_t;

	state_t state_q;
	logic   emit_q;
	logic   no_out_q;
	logic   rst_pend_q;

	logic signed [ENV_W-1:0]        env_q;
	logic [FRAC_BITS-1:0]           res_q;
	logic [GAIN_W-1:0]              gain_q;
	logic signed [SAMPLE_WIDTH-1:0] s_q;
	logic [MAG_W-1:0]               mag_q;
	logic signed [ENV_W-1:0]        diff_q;
	logic [LEVEL_W-1:0]             coeff_q;
	logic signed [63:0]             fine_q;
	logic [NUM_W-1:0]               gq_q;
	logic signed [SAMPLE_WIDTH+GAIN_W:0] prod_q;
	logic signed [OUT_W-1:0]        res_out_q;
	logic [GAIN_W-1:0]              gain_out_q;
	logic                           out_v_q;

	logic signed [63:0]       step;
	logic signed [ENV_W-1:0]  env_new;
	logic signed [ENV_W-1:0]  floor_env;
	logic [LEVEL_W-1:0]       floor_eff;
	logic                     clamped;
	logic                     div_start;
	logic [NUM_W-1:0]         div_num;
	logic [ENV_W-1:0]         div_den;
	logic                     div_busy;
	logic                     div_done;
	logic [NUM_W-1:0]         div_quot;
	logic [NUM_W-1:0]         g_lo;
	logic [NUM_W-1:0]         g_hi;
	logic                     out_free;

	assign floor_eff = (cfg.floor_lvl == '0) ? LEVEL_W'(1) : cfg.floor_lvl;
	assign floor_env = ENV_W'({floor_eff, {FRAC_BITS{1'b0}}});
	assign step      = fine_q >>> FRAC_BITS;
	assign env_new   = env_q + step[ENV_W-1:0];
	assign clamped   = env_new < floor_env;
	assign out_free  = !out_v_q || !out_stall;

	assign pop = (state_q == S_IDLE) && !rst_pend_q && q_not_empty && !emit_q;

	always_comb begin
		div_start = 1'b0;
		div_num   = '0;
		div_den   = ENV_W'(1);
		if (state_q == S_DGS) begin
			div_start = 1'b1;
			div_num   = {cfg.target, {(GAIN_SHIFT + FRAC_BITS){1'b0}}};
			div_den   = (env_q <= 0) ? ENV_W'(1) : env_q;
		end else if (state_q == S_DMS) begin
			div_start = 1'b1;
			div_num   = NUM_W'({cfg.target, {GAIN_SHIFT{1'b0}}});
			div_den   = ENV_W'(floor_eff);
		end
	end

	pagc_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (div_num),
		.den   (div_den),
		.busy  (div_busy),
		.done  (div_done),
		.quot  (div_quot)
	);

	always_comb begin
		g_lo = (gq_q < NUM_W'(cfg.gmin)) ? NUM_W'(cfg.gmin) : gq_q;
		g_hi = (g_lo > div_quot) ? div_quot : g_lo;
		if (g_hi > NUM_W'(GAIN_LIMIT)) g_hi = NUM_W'(GAIN_LIMIT);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			emit_q     <= 1'b0;
			no_out_q   <= 1'b0;
			rst_pend_q <= 1'b0;
			out_v_q    <= 1'b0;
			env_q      <= ENV_W'({TARGET_RST, {FRAC_BITS{1'b0}}});
			res_q      <= '0;
			gain_q     <= GAIN_UNITY;
		end else begin
			if (emit_q && out_free) begin
				emit_q  <= 1'b0;
				out_v_q <= 1'b1;
			end else if (!out_stall) begin
				out_v_q <= 1'b0;
			end
			if (cfg.restart) begin
				env_q      <= ENV_W'({cfg.target, {FRAC_BITS{1'b0}}});
				res_q      <= '0;
				rst_pend_q <= 1'b1;
			end
			unique case (state_q)
				S_IDLE: begin
					if (rst_pend_q && !emit_q) begin
						rst_pend_q <= 1'b0;
						no_out_q   <= 1'b1;
						state_q    <= S_DGS;
					end else if (pop) begin
						no_out_q <= 1'b0;
						if (!cfg.enable) emit_q <= 1'b1;
						else state_q <= S_CALC;
					end
				end
				S_CALC: state_q <= S_STEP;
				S_STEP: state_q <= S_UPD;
				S_UPD: begin
					env_q   <= clamped ? floor_env : env_new;
					res_q   <= fine_q[FRAC_BITS-1:0];
					state_q <= (step != 0 || clamped) ? S_DGS : S_MULT;
				end
				S_DGS: state_q <= S_DGW;
				S_DGW: if (div_done) state_q <= S_DMS;
				S_DMS: state_q <= S_DMW;
				S_DMW: if (div_done) state_q <= S_CLMP;
				S_CLMP: begin
					gain_q  <= g_hi[GAIN_W-1:0];
					state_q <= no_out_q ? S_IDLE : S_MULT;
				end
				S_MULT: begin
					emit_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			s_q   <= q_item.sample;
			mag_q <= q_item.mag;
			if (!cfg.enable)
				prod_q <= (SAMPLE_WIDTH+GAIN_W+1)'(q_item.sample) <<< GAIN_SHIFT;
		end
		if (state_q == S_CALC) begin
			diff_q  <= ENV_W'({mag_q, {FRAC_BITS{1'b0}}}) - env_q;
			coeff_q <= (ENV_W'({mag_q, {FRAC_BITS{1'b0}}}) > env_q) ? cfg.attack
				: cfg.release_c;
		end
		if (state_q == S_STEP)
			fine_q <= 64'(diff_q * $signed({1'b0, coeff_q})) + 64'($signed({1'b0, res_q}));
		if (state_q == S_DGW && div_done) gq_q <= div_quot;
		if (state_q == S_MULT) begin
			prod_q <= s_q * $signed({1'b0, gain_q});
		end
		if (emit_q && out_free && !no_out_q) begin
			res_out_q  <= prod_q[GAIN_SHIFT +: OUT_W];
			gain_out_q <= cfg.enable ? gain_q : GAIN_UNITY;
		end
	end

	assign out_valid     = out_v_q;
	assign scaled_sample = res_out_q;
	assign current_gain  = gain_out_q;
	assign st.idle       = (state_q == S_IDLE) && !rst_pend_q;
	assign st.div_busy   = div_busy;

endmodule

### design/peak_envelope_agc.sv
// ----------------------------------------------------------------------------
// peak_envelope_agc
// automatic gain control driven by a peak envelope follower
// ----------------------------------------------------------------------------
// usage:
//  input channel: sample with in_valid / in_stall; a beat moves when valid is
//  high and stall is low. output channel: scaled_sample and current_gain with
//  out_valid / out_stall, same rule.
//  config channel: cfg_valid / cfg_ready with cfg_index and cfg_data; write
//  only while idle. cfg_ready is low while the back end is busy.
//  the gain is recomputed when the envelope step is nonzero or the floor
//  clamps it: two 38-step divisions run on the shared radix-2 divider.
//  disabled beats skip the envelope and pass at unity gain. the back end
//  works on one beat at a time while the queue keeps taking samples.
//  an enable write from 0 to 1 restarts the envelope and runs one gain
//  recompute, during which no sample is taken.
//  reset: registers take their defaults, envelope holds target << 15, gain is
//  unity. a stalled output holds its beat; the two-entry queue keeps taking
//  samples until it fills, then in_stall rises.
// ----------------------------------------------------------------------------
module peak_envelope_agc (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      in_valid,
	output logic                                      in_stall,
	input  logic signed [pagc_pkg::SAMPLE_WIDTH-1:0]  sample,
	output logic                                      out_valid,
	input  logic                                      out_stall,
	output logic signed [pagc_pkg::OUT_W-1:0]         scaled_sample,
	output logic [pagc_pkg::GAIN_W-1:0]               current_gain,
	input  logic                                      cfg_valid,
	output logic                                      cfg_ready,
	input  logic [pagc_pkg::IDX_W-1:0]                cfg_index,
	input  logic [pagc_pkg::DATA_W-1:0]               cfg_data
);
	import pagc_pkg::*;

	cfg_t     cfg;
	back_st_t st;
	logic     push;
	item_t    push_item;
	logic     q_full;
	logic     q_not_empty;
	item_t    q_item;
	logic     pop;
	logic     wr;

	logic               enable_q;
	logic [LEVEL_W-1:0] target_q;
	logic [LEVEL_W-1:0] floor_q;
	logic [GAIN_W-1:0]  gmin_q;
	logic [LEVEL_W-1:0] attack_q;
	logic [LEVEL_W-1:0] release_q;

	assign cfg_ready = st.idle && !st.div_busy;
	assign wr        = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q  <= 1'b1;
			target_q  <= TARGET_RST;
			floor_q   <= FLOOR_RST;
			gmin_q    <= GMIN_RST;
			attack_q  <= ATTACK_RST;
			release_q <= RELEASE_RST;
		end else if (wr) begin
			unique case (cfg_index)
				REG_ENABLE:  enable_q  <= cfg_data[0];
				REG_TARGET:  target_q  <= cfg_data[LEVEL_W-1:0];
				REG_FLOOR:   floor_q   <= cfg_data[LEVEL_W-1:0];
				REG_GMIN:    gmin_q    <= cfg_data[GAIN_W-1:0];
				REG_ATTACK:  attack_q  <= cfg_data[LEVEL_W-1:0];
				REG_RELEASE: release_q <= cfg_data[LEVEL_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg.enable    = enable_q;
	assign cfg.target    = target_q;
	assign cfg.floor_lvl = floor_q;
	assign cfg.gmin      = gmin_q;
	assign cfg.attack    = attack_q;
	assign cfg.release_c = release_q;
	assign cfg.restart   = wr && (cfg_index == REG_ENABLE) && cfg_data[0] && !enable_q;

	pagc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sample   (sample),
		.push     (push),
		.push_item(push_item),
		.q_full   (q_full)
	);

	pagc_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_item(push_item),
		.full     (q_full),
		.pop      (pop),
		.not_empty(q_not_empty),
		.pop_item (q_item)
	);

	pagc_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.q_not_empty  (q_not_empty),
		.q_item       (q_item),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.scaled_sample(scaled_sample),
		.current_gain (current_gain),
		.st           (st)
	);

`ifndef SYNTHESIS
	a_cfg_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready |-> (st.idle && !st.div_busy))
		else $error("config taken while back end busy");
	a_restart_holds: assert property (@(posedge clk) disable iff (!arst_n)
		cfg.restart |=> !cfg_ready)
		else $error("restart did not block config");
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> q_not_empty && !st.div_busy)
		else $error("pop while empty or dividing");
`endif

endmodule

### sim/tb_peak_envelope_agc.sv
// ----------------------------------------------------------------------------
// tb_peak_envelope_agc
// self-checking bench: random and directed samples under changing register
// settings, every output beat compared with a software envelope and gain model
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_peak_envelope_agc;
	import pagc_pkg::*;

	localparam logic [IDX_W-1:0] REG_SPARE = 3'd6;
	localparam longint SMAX = 64'sd2147483647;
	localparam longint OMAX = 64'sd70368744177663;

	typedef struct {
		logic signed [OUT_W-1:0] scaled;
		logic [GAIN_W-1:0]       gain;
	} agc_beat_t;

	class agc_scoreboard;
		bit     en;
		longint tgt, flr, gmin, att, rel;
		longint env, res, gain;
		agc_beat_t pending[$];
		int     errors;

		function void recompute();
			longint dv, g, gmax, fl;
			dv = env <= 0 ? 1 : env;
			fl = flr == 0 ? 1 : flr;
			g = (tgt <<< (GAIN_SHIFT + FRAC_BITS)) / dv;
			gmax = (tgt <<< GAIN_SHIFT) / fl;
			if (g < gmin) g = gmin;
			if (g > gmax) g = gmax;
			if (g > longint'(GAIN_LIMIT)) g = GAIN_LIMIT;
			gain = g;
		endfunction

		function void restart();
			env = tgt <<< FRAC_BITS;
			res = 0;
			recompute();
		endfunction

		function new();
			en = 1; tgt = 5000; flr = 16; gmin = 26; att = 512; rel = 1;
			errors = 0;
			restart();
		endfunction

		function void write_reg(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] d);
			case (idx)
				REG_ENABLE: begin
					if (d[0] && !en) restart();
					en = d[0];
				end
				REG_TARGET:  tgt = d[LEVEL_W-1:0];
				REG_FLOOR:   flr = d[LEVEL_W-1:0];
				REG_GMIN:    gmin = d[GAIN_W-1:0];
				REG_ATTACK:  att = d[LEVEL_W-1:0];
				REG_RELEASE: rel = d[LEVEL_W-1:0];
				default: ;
			endcase
		endfunction

		function void note(logic signed [SAMPLE_WIDTH-1:0] s);
			longint sv, mag, diff, coeff, fine, stp, was, fl, r;
			agc_beat_t e;
			sv = s;
			if (!en) begin
				e.scaled = OUT_W'(sv);
				e.gain = GAIN_UNITY;
				pending.push_back(e);
				return;
			end
			mag = sv < 0 ? (sv < -SMAX ? SMAX : -sv) : sv;
			diff = (mag <<< FRAC_BITS) - env;
			coeff = diff > 0 ? att : rel;
			fine = diff * coeff + res;
			stp = fine >>> FRAC_BITS;
			env += stp;
			res = fine - (stp <<< FRAC_BITS);
			was = env;
			fl = flr == 0 ? 1 : flr;
			if (env < (fl <<< FRAC_BITS)) env = fl <<< FRAC_BITS;
			if (stp != 0 || env != was) recompute();
			r = (sv * gain) >>> GAIN_SHIFT;
			if (r > OMAX) r = OMAX;
			if (r < -OMAX - 1) r = -OMAX - 1;
			e.scaled = OUT_W'(r);
			e.gain = GAIN_W'(gain);
			pending.push_back(e);
		endfunction

		function void check(logic signed [OUT_W-1:0] ss, logic [GAIN_W-1:0] g);
			agc_beat_t e;
			if (pending.size() == 0) begin
				$error("unexpected output beat scaled_sample=%0d", ss);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (ss !== e.scaled) begin
				$error("scaled_sample expected %0d actual %0d", e.scaled, ss);
				errors++;
			end
			if (g !== e.gain) begin
				$error("current_gain expected %0d actual %0d", e.gain, g);
				errors++;
			end
		endfunction
	endclass

	logic clk, arst_n;
	logic in_valid, in_stall, out_valid, out_stall, cfg_valid, cfg_ready;
	logic signed [SAMPLE_WIDTH-1:0] sample;
	logic signed [OUT_W-1:0] scaled_sample;
	logic [GAIN_W-1:0] current_gain;
	logic [IDX_W-1:0] cfg_index;
	logic [DATA_W-1:0] cfg_data;
	bit quiet;
	agc_scoreboard sb;

	peak_envelope_agc dut (.*);

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
			if (in_valid && !in_stall) sb.note(sample);
			if (out_valid && !out_stall) sb.check(scaled_sample, current_gain);
		end
	end

	int stall_left;
	always @(negedge clk) begin
		if (quiet) begin
			out_stall <= 0;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_stall <= 1;
		end else if ($urandom_range(0, 5) == 0) begin
			stall_left <= $urandom_range(0, 5);
			out_stall <= 1;
		end else begin
			out_stall <= 0;
		end
	end

	task automatic drain();
		@(negedge clk);
		in_valid = 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	task automatic write_reg(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] d);
		drain();
		@(negedge clk);
		cfg_valid = 1;
		cfg_index = idx;
		cfg_data = d;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 0;
	endtask

	task automatic send(logic signed [SAMPLE_WIDTH-1:0] s);
		@(negedge clk);
		in_valid = 1;
		sample = s;
		do @(posedge clk); while (in_stall);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			@(negedge clk);
			in_valid = 0;
			repeat ($urandom_range(1, 6) - 1) @(negedge clk);
		end
	endtask

	function automatic logic signed [SAMPLE_WIDTH-1:0] rand_sample();
		case ($urandom_range(0, 5))
			0: return $urandom;
			1: return $signed($urandom_range(0, 200)) - 100;
			2: return $signed($urandom_range(0, 65535)) - 32768;
			3: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
			default: return $signed($urandom) >>> $urandom_range(0, 28);
		endcase
	endfunction

	task automatic random_config();
		write_reg(REG_TARGET, $urandom_range(0, 2) == 0 ?
			($urandom_range(0, 1) ? 23'd1 : 23'h7fff) : DATA_W'($urandom));
		write_reg(REG_FLOOR, $urandom_range(0, 2) == 0 ?
			($urandom_range(0, 1) ? 23'd1 : 23'd0) : DATA_W'($urandom_range(0, 2000)));
		write_reg(REG_GMIN, $urandom_range(0, 2) == 0 ?
			($urandom_range(0, 1) ? 23'd0 : 23'd8388352) : DATA_W'($urandom_range(0, 1000)));
		write_reg(REG_ATTACK, $urandom_range(0, 2) == 0 ? 23'h7fff : DATA_W'($urandom));
		write_reg(REG_RELEASE, $urandom_range(0, 2) == 0 ?
			($urandom_range(0, 1) ? 23'd0 : 23'h7fff) : DATA_W'($urandom));
		if ($urandom_range(0, 2) == 0) write_reg(REG_ENABLE, 23'd0);
		write_reg(REG_ENABLE, DATA_W'($urandom_range(0, 3) != 0));
	endtask

	initial begin
		sb = new();
		quiet = 0;
		stall_left = 0;
		arst_n = 0;
		in_valid = 0;
		sample = 0;
		cfg_valid = 0;
		cfg_index = REG_ENABLE;
		cfg_data = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// extremes with reset registers
		send(0); send(1); send(-1); send(32'sh7fffffff); send(32'sh80000000);
		send(32'sh80000001); send(5000); send(-5000); send(100);
		// disabled pass-through, then restart on enable
		write_reg(REG_ENABLE, 23'd0);
		send(32'sh80000000); send(-7); send(32'sh7fffffff);
		write_reg(REG_ENABLE, 23'd1);
		send(12);
		// zero floor, zero target, full coefficients, gain limits
		write_reg(REG_FLOOR, 23'd0);
		write_reg(REG_RELEASE, 23'h7fff);
		send(0); send(0);
		write_reg(REG_TARGET, 23'd0);
		send(1000); send(-3);
		write_reg(REG_TARGET, 23'h7fff);
		write_reg(REG_GMIN, 23'd8388352);
		write_reg(REG_ATTACK, 23'h7fff);
		send(32'sh80000000); send(32'sh7fffffff); send(-1);
		write_reg(REG_GMIN, 23'd0);
		write_reg(REG_SPARE, 23'h7fffff);
		send(0); send(42);

		for (int ph = 0; ph < 8; ph++) begin
			random_config();
			for (int i = 0; i < 50; i++) begin
				if (ph == 7 && i == 20) quiet = 1;
				if (ph == 3 && i == 25) begin
					@(negedge clk);
					in_valid = 0;
					while (sb.pending.size() != 0) @(posedge clk);
				end
				send(rand_sample());
			end
		end
		@(negedge clk);
		in_valid = 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (sb.errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		#5ms;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
